@@ hw/rtl/grid_cell_occupancy_detector_assert.svh @@
// Assertion macros for the grid cell occupancy detector checkers.
// Both macros expect clk and rst in scope and are disabled during reset.
`ifndef GRID_CELL_OCCUPANCY_DETECTOR_ASSERT_SVH
`define GRID_CELL_OCCUPANCY_DETECTOR_ASSERT_SVH

// Same-cycle implication.
`define GCOD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GCOD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/gcod_pkg.sv @@
// ----------------------------------------------------------------------------
// gcod_pkg
// Types and constants shared by the grid cell occupancy detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gcod_pkg;

  // Sampling pitch inside a cell, a power of two
  localparam int SAMPLE_SHIFT = 2;
  localparam int SAMPLE_STEP  = 1 << SAMPLE_SHIFT;
  localparam int MAX_ROWS     = 64;
  localparam int COUNT_W      = 13;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam int POS_SAT      = 127;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH = 3'd0,
    REG_CELL_WIDTH  = 3'd1,
    REG_CELL_HEIGHT = 3'd2,
    REG_GRID_COLS   = 3'd3,
    REG_GRID_ROWS   = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } pixel_t;

  typedef struct packed {
    logic [11:0] cell_index;
    logic [5:0]  cell_col;
    logic [5:0]  cell_row;
    logic        occupied;
  } cell_t;

  typedef struct packed {
    logic [12:0] image_width;
    logic [8:0]  cell_width;
    logic [8:0]  cell_height;
    logic [6:0]  grid_cols;
    logic [6:0]  grid_rows;
  } cfg_t;

  // Per-pixel update handed from the position tracker to the counter stage
  typedef struct packed {
    logic        live;   // pixel lies inside the grid
    logic        first;  // top-left pixel of its cell
    logic        inc;    // sampled and not black
    logic        last;   // bottom-right pixel of its cell
    logic [6:0]  col;
    logic [5:0]  row;
    logic [11:0] index;
  } cell_op_t;

endpackage

@@ hw/rtl/gcod_ram.sv @@
// ----------------------------------------------------------------------------
// gcod_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcod_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/gcod_pos.sv @@
// ----------------------------------------------------------------------------
// gcod_pos
// Raster position tracker: decodes each incoming pixel into a cell update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcod_pos #(
  parameter int MAX_COLS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  gcod_pkg::pixel_t  pixel,
  input  gcod_pkg::cfg_t    cfg,
  output gcod_pkg::cell_op_t op
);

  logic [11:0] line_pos;
  logic [7:0]  x_in_cell;
  logic [6:0]  cell_col_pos;
  logic [7:0]  y_in_cell;
  logic [6:0]  cell_row_pos;

  logic [11:0] line_pos_next;
  logic [7:0]  x_in_cell_next;
  logic [6:0]  cell_col_pos_next;
  logic [7:0]  y_in_cell_next;
  logic [6:0]  cell_row_pos_next;

  logic [11:0] px;
  logic [7:0]  xc;
  logic [6:0]  pcol;
  logic [7:0]  yc;
  logic [6:0]  prow;
  logic [11:0] iw_m1;
  logic [7:0]  cw_m1;
  logic [7:0]  ch_m1;
  logic [6:0]  cols;
  logic [6:0]  rows;
  logic [13:0] area;
  logic [13:0] lin;
  logic        hit;
  logic        sampled;

  // A frame start places this pixel at the origin
  assign px   = pixel.frame_start ? '0 : line_pos;
  assign xc   = pixel.frame_start ? '0 : x_in_cell;
  assign pcol = pixel.frame_start ? '0 : cell_col_pos;
  assign yc   = pixel.frame_start ? '0 : y_in_cell;
  assign prow = pixel.frame_start ? '0 : cell_row_pos;

  always_comb begin
    if (cfg.image_width == '0) begin
      iw_m1 = '0;
    end else if (cfg.image_width >= 13'd4096) begin
      iw_m1 = '1;
    end else begin
      iw_m1 = 12'(cfg.image_width - 13'd1);
    end
    if (cfg.cell_width == '0) begin
      cw_m1 = '0;
    end else if (cfg.cell_width >= 9'd256) begin
      cw_m1 = '1;
    end else begin
      cw_m1 = 8'(cfg.cell_width - 9'd1);
    end
    if (cfg.cell_height == '0) begin
      ch_m1 = '0;
    end else if (cfg.cell_height >= 9'd256) begin
      ch_m1 = '1;
    end else begin
      ch_m1 = 8'(cfg.cell_height - 9'd1);
    end
  end

  assign cols = (int'(cfg.grid_cols) > MAX_COLS) ? 7'(MAX_COLS) : cfg.grid_cols;
  assign rows = ({2'b00, cfg.grid_rows} > 9'(gcod_pkg::MAX_ROWS)) ?
                7'(gcod_pkg::MAX_ROWS) : cfg.grid_rows;

  assign hit     = (pixel.red | pixel.green | pixel.blue) != 8'd0;
  assign sampled = (xc[gcod_pkg::SAMPLE_SHIFT-1:0] == '0) &&
                   (yc[gcod_pkg::SAMPLE_SHIFT-1:0] == '0);

  // Mirrored map index, kept modulo the 12-bit field
  assign area = 14'(rows) * 14'(cols);
  assign lin  = 14'(cols) * 14'(prow) + 14'(pcol);

  always_comb begin
    op.live  = (pcol < cols) && (prow < rows);
    op.first = (xc == '0) && (yc == '0);
    op.inc   = sampled && hit;
    op.last  = (xc == cw_m1) && (yc == ch_m1);
    op.col   = pcol;
    op.row   = prow[5:0];
    op.index = 12'(area - 14'd1 - lin);
  end

  always_comb begin
    line_pos_next     = px;
    x_in_cell_next    = xc;
    cell_col_pos_next = pcol;
    y_in_cell_next    = yc;
    cell_row_pos_next = prow;
    if (px >= iw_m1) begin
      // wrap to the next line
      line_pos_next     = '0;
      x_in_cell_next    = '0;
      cell_col_pos_next = '0;
      if (yc >= ch_m1) begin
        y_in_cell_next = '0;
        if (prow < 7'(gcod_pkg::POS_SAT)) begin
          cell_row_pos_next = prow + 7'd1;
        end
      end else begin
        y_in_cell_next = yc + 8'd1;
      end
    end else begin
      line_pos_next = px + 12'd1;
      if (xc >= cw_m1) begin
        x_in_cell_next = '0;
        if (pcol < 7'(gcod_pkg::POS_SAT)) begin
          cell_col_pos_next = pcol + 7'd1;
        end
      end else begin
        x_in_cell_next = xc + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_pos     <= '0;
      x_in_cell    <= '0;
      cell_col_pos <= '0;
      y_in_cell    <= '0;
      cell_row_pos <= '0;
    end else if (accept) begin
      line_pos     <= line_pos_next;
      x_in_cell    <= x_in_cell_next;
      cell_col_pos <= cell_col_pos_next;
      y_in_cell    <= y_in_cell_next;
      cell_row_pos <= cell_row_pos_next;
    end
  end

endmodule

@@ hw/rtl/gcod_acc.sv @@
// ----------------------------------------------------------------------------
// gcod_acc
// Column count read-modify-write stage around the count RAM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcod_acc #(
  parameter int MAX_COLS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  gcod_pkg::cell_op_t op,
  input  gcod_pkg::cfg_t     cfg,
  input  logic               out_free,
  output logic               ready,
  output logic               res_valid,
  output gcod_pkg::cell_t    res
);

  localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int VD = 1 << AW;
  localparam int CW = gcod_pkg::COUNT_W;

  logic               s1_valid;
  gcod_pkg::cell_op_t s1_op;
  logic               s1_seen;
  logic               s1_adv;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      s1_addr;
  logic [CW-1:0]      rdata;
  logic [VD-1:0]      seen;
  logic               wr_valid;
  logic [AW-1:0]      wr_addr;
  logic [CW-1:0]      wr_data;
  logic [CW-1:0]      old_cnt;
  logic [CW-1:0]      base_cnt;
  logic [CW-1:0]      new_cnt;
  logic               we;
  logic [8:0]         cwc;
  logic [8:0]         chc;
  logic [15:0]        area;
  logic [CW-1:0]      thresh;

  assign rd_addr = AW'(op.col);
  assign s1_addr = AW'(s1_op.col);

  gcod_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_COLS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (s1_addr),
    .wdata (new_cnt),
    .re    (accept && op.live),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // Hold while a finished cell cannot move into the output register
  assign s1_adv = !s1_op.last || out_free;
  assign ready  = !s1_valid || s1_adv;
  assign we     = s1_valid && s1_adv;

  // Take the newest write when it hit the same column; unwritten columns read zero
  always_comb begin
    if (wr_valid && (wr_addr == s1_addr)) begin
      old_cnt = wr_data;
    end else if (s1_seen) begin
      old_cnt = rdata;
    end else begin
      old_cnt = '0;
    end
    base_cnt = s1_op.first ? '0 : old_cnt;
    new_cnt  = (s1_op.inc && (base_cnt != gcod_pkg::COUNT_MAX)) ? base_cnt + 1'b1 : base_cnt;
  end

  always_comb begin
    if (cfg.cell_width == '0) begin
      cwc = 9'd1;
    end else if (cfg.cell_width > 9'd256) begin
      cwc = 9'd256;
    end else begin
      cwc = cfg.cell_width;
    end
    if (cfg.cell_height == '0) begin
      chc = 9'd1;
    end else if (cfg.cell_height > 9'd256) begin
      chc = 9'd256;
    end else begin
      chc = cfg.cell_height;
    end
  end

  assign area   = 16'(cwc >> gcod_pkg::SAMPLE_SHIFT) * 16'(chc);
  assign thresh = CW'(area >> gcod_pkg::SAMPLE_SHIFT);

  assign res_valid = s1_valid && s1_op.last;

  always_comb begin
    res.cell_index = s1_op.index;
    res.cell_col   = s1_op.col[5:0];
    res.cell_row   = s1_op.row;
    res.occupied   = (new_cnt != '0) && ({new_cnt, 1'b0} >= {1'b0, thresh});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      wr_valid <= 1'b0;
      seen     <= '0;
    end else begin
      if (accept) begin
        s1_valid <= op.live;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (we) begin
        wr_valid      <= 1'b1;
        seen[s1_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op   <= op;
      s1_seen <= seen[rd_addr];
    end
    if (we) begin
      wr_addr <= s1_addr;
      wr_data <= new_cnt;
    end
  end

endmodule

@@ hw/rtl/grid_cell_occupancy_detector.sv @@
// ----------------------------------------------------------------------------
// grid_cell_occupancy_detector
// Per-cell foreground occupancy over a raster pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter on in_valid/in_ready, one transaction per pixel, line by line;
// frame_start puts a pixel at the top-left corner. Each pixel that completes
// a grid cell yields one transaction on out_valid/out_ready carrying the
// cell's column, row, mirrored map index and occupancy flag.
// Throughput: one pixel per clock while in_ready is high. The per-column hit
// count is read from the count RAM at acceptance and written back when the
// stage advances; the next pixel of the same column takes the written value
// by forwarding. A cell's result passes through the stage register and then
// the output register, where it waits until out_ready takes it.
// While a result waits in the output register, pixels are still accepted;
// in_ready drops only when a second finished cell is waiting behind it.
// Reset: configuration returns to 640 wide, 80 by 60 cells, 8 by 8 grid;
// the position returns to the origin and all column counts read as zero
// until written, with no clearing pass. The user must write configuration
// via cfg_we/cfg_index/cfg_data only while idle, unenforced by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_cell_occupancy_detector #(
  parameter int MAX_COLS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  gcod_pkg::pixel_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output gcod_pkg::cell_t  out_data,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [12:0]      cfg_data
);

  gcod_pkg::cfg_t     cfg;
  gcod_pkg::cell_op_t op;
  gcod_pkg::cell_t    res;
  logic               accept;
  logic               out_free;
  logic               res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width <= 13'd640;
      cfg.cell_width  <= 9'd80;
      cfg.cell_height <= 9'd60;
      cfg.grid_cols   <= 7'd8;
      cfg.grid_rows   <= 7'd8;
    end else if (cfg_we) begin
      unique case (gcod_pkg::reg_index_t'(cfg_index))
        gcod_pkg::REG_IMAGE_WIDTH: cfg.image_width <= cfg_data;
        gcod_pkg::REG_CELL_WIDTH:  cfg.cell_width  <= cfg_data[8:0];
        gcod_pkg::REG_CELL_HEIGHT: cfg.cell_height <= cfg_data[8:0];
        gcod_pkg::REG_GRID_COLS:   cfg.grid_cols   <= cfg_data[6:0];
        gcod_pkg::REG_GRID_ROWS:   cfg.grid_rows   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  gcod_pos #(
    .MAX_COLS (MAX_COLS)
  ) u_pos (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .pixel  (in_data),
    .cfg    (cfg),
    .op     (op)
  );

  gcod_acc #(
    .MAX_COLS (MAX_COLS)
  ) u_acc (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .op        (op),
    .cfg       (cfg),
    .out_free  (out_free),
    .ready     (in_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      out_data <= res;
    end
  end

endmodule

@@ hw/rtl/gcod_chk.sv @@
// ----------------------------------------------------------------------------
// gcod_chk
// Port-level checks for the grid cell occupancy detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "grid_cell_occupancy_detector_assert.svh"

module gcod_chk (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input gcod_pkg::cell_t out_data
);

  `GCOD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
  `GCOD_ASSERT_NOW(a_ready_only_on_stall, !in_ready, out_valid && !out_ready, "input stalled without a waiting result")
  `GCOD_ASSERT_NOW(a_clean_after_reset, $fell(rst), !out_valid, "result present straight after reset")
  `GCOD_ASSERT_NOW(a_result_has_cause, $rose(out_valid), $past(in_valid && in_ready, 2), "result without an accepted pixel")

endmodule

bind grid_cell_occupancy_detector gcod_chk u_chk (.*);
